// ----- rtl/core/ple_pkg.sv -----
// Shared types and constants of the positional list engine.
package ple_pkg;

  // Width of positions and counts inside the cell chain (covers capacities up to 2047).
  localparam int POS_W = 11;

  // Field widths on the streams.
  localparam int CMD_W    = 3;
  localparam int PIDX_W   = 7;
  localparam int VALUE_W  = 32;
  localparam int STAT_W   = 2;
  localparam int ECOUNT_W = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_RETRIEVE    = 3'd2,
    CMD_REPLACE     = 3'd3,
    CMD_INTERCHANGE = 3'd4,
    CMD_MEDIAN      = 3'd5,
    CMD_REVERSE     = 3'd6,
    CMD_CLEAR       = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SWAP,
    S_REV,
    S_DONE
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic               load;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
  } cell_cmd_t;

endpackage

// ----- rtl/core/ple_cell.sv -----
// One storage cell of the list chain: entry word plus read-out shift stage.
module ple_cell #(
  parameter int ENTRY_WIDTH = 32,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  ple_pkg::cell_cmd_t     cmd_i,
  input  logic [ENTRY_WIDTH-1:0] data_a_i,
  input  logic [ENTRY_WIDTH-1:0] data_b_i,
  input  logic [ENTRY_WIDTH-1:0] up_i,     // entry of the cell below
  input  logic [ENTRY_WIDTH-1:0] dn_i,     // entry of the cell above
  input  logic [ENTRY_WIDTH-1:0] head_i,   // entry of cell 0
  input  logic [ENTRY_WIDTH-1:0] rd_i,     // read stage of the cell above
  output logic [ENTRY_WIDTH-1:0] data_o,
  output logic [ENTRY_WIDTH-1:0] rd_o
);

  localparam int PW = ple_pkg::POS_W;
  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [ENTRY_WIDTH-1:0] data_r, data_nxt;
  logic [ENTRY_WIDTH-1:0] rdv_r, rdv_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd_i.op)
      ple_pkg::CELL_HOLD: data_nxt = data_r;
      ple_pkg::CELL_INSERT: begin
        if (MY_IDX > cmd_i.pos_a) data_nxt = up_i;
        else if (MY_IDX == cmd_i.pos_a) data_nxt = data_a_i;
      end
      ple_pkg::CELL_REMOVE: begin
        if (MY_IDX >= cmd_i.pos_a) data_nxt = dn_i;
      end
      ple_pkg::CELL_WRITE: begin
        if (MY_IDX == cmd_i.pos_a) data_nxt = data_a_i;
        else if (MY_IDX == cmd_i.pos_b) data_nxt = data_b_i;
      end
      // move the head word to pos_a, shift everything below it down one
      ple_pkg::CELL_ROTATE: begin
        if (MY_IDX < cmd_i.pos_a) data_nxt = dn_i;
        else if (MY_IDX == cmd_i.pos_a) data_nxt = head_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  // snapshot all entries, then shift toward cell 0 one step a cycle
  assign rdv_nxt = cmd_i.load ? data_r : rd_i;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rdv_r  <= rdv_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = rdv_r;

endmodule

// ----- rtl/core/ple_ctrl.sv -----
// Command sequencer of the positional list engine: decode, count, scan and result register.
module ple_ctrl #(
  parameter int CAPACITY    = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ple_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [ple_pkg::CMD_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ple_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [ple_pkg::STAT_W-1:0]          out_tuser,
  input  logic [ENTRY_WIDTH-1:0]              rd_head_i,
  output ple_pkg::cell_cmd_t                  cell_cmd_o,
  output logic [ENTRY_WIDTH-1:0]              data_a_o,
  output logic [ENTRY_WIDTH-1:0]              data_b_o
);

  localparam int PW = ple_pkg::POS_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int MW = (ENTRY_WIDTH > 32) ? ENTRY_WIDTH : 32;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  ple_pkg::fsm_t    state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  ple_pkg::cmd_t    cmd_r;
  logic [6:0]       p_r, q_r;
  logic [ENTRY_WIDTH-1:0] val_r;
  logic [IW-1:0]    k_r, k_nxt, tgt_r, tgt_nxt, sec_r, sec_nxt, last_r, last_nxt;
  logic [IW-1:0]    m_r, m_nxt;
  logic [ENTRY_WIDTH-1:0] tmp_a_r, tmp_a_nxt, tmp_b_r, tmp_b_nxt;
  ple_pkg::status_t stat_r, stat_nxt;
  logic [ple_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [ple_pkg::STAT_W-1:0]      out_tuser_r, out_tuser_nxt;

  logic             accept;
  logic [MW-1:0]    val_ext, rd_ext;
  logic [PW-1:0]    cnt_p, pp, qq;
  logic             p_in, q_in, has_rd;
  logic [IW-1:0]    p_i, q_i, med_i;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ple_pkg::S_IDLE);
  assign val_ext   = MW'(in_tdata[45:14]);

  assign cnt_p = PW'(count_r);
  assign pp    = PW'(p_r);
  assign qq    = PW'(q_r);
  assign p_in  = pp < cnt_p;
  assign q_in  = qq < cnt_p;
  assign p_i   = IW'(p_r);
  assign q_i   = IW'(q_r);
  assign med_i = IW'(CW'(count_r - 1'b1) >> 1);

  assign has_rd = (stat_r == ple_pkg::STAT_OK) &&
                  (cmd_r inside {ple_pkg::CMD_REMOVE, ple_pkg::CMD_RETRIEVE,
                                 ple_pkg::CMD_MEDIAN});
  assign rd_ext = has_rd ? MW'(tmp_a_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    k_nxt         = k_r;
    tgt_nxt       = tgt_r;
    sec_nxt       = sec_r;
    last_nxt      = last_r;
    m_nxt         = m_r;
    tmp_a_nxt     = tmp_a_r;
    tmp_b_nxt     = tmp_b_r;
    stat_nxt      = stat_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    cell_cmd_o    = '{op: ple_pkg::CELL_HOLD, load: 1'b0, pos_a: '0, pos_b: '0};
    data_a_o      = val_r;
    data_b_o      = val_r;

    case (state_r)
      ple_pkg::S_IDLE: begin
        if (accept) state_nxt = ple_pkg::S_EXEC;
      end

      ple_pkg::S_EXEC: begin
        stat_nxt  = ple_pkg::STAT_OK;
        state_nxt = ple_pkg::S_DONE;
        k_nxt     = '0;
        case (cmd_r)
          ple_pkg::CMD_INSERT: begin
            if (count_r == FULL_CNT) stat_nxt = ple_pkg::STAT_OVERFLOW;
            else if (pp > cnt_p) stat_nxt = ple_pkg::STAT_RANGE;
            else begin
              cell_cmd_o.op    = ple_pkg::CELL_INSERT;
              cell_cmd_o.pos_a = pp;
              count_nxt        = CW'(count_r + 1'b1);
            end
          end
          ple_pkg::CMD_REMOVE, ple_pkg::CMD_RETRIEVE: begin
            if (!p_in) stat_nxt = ple_pkg::STAT_RANGE;
            else begin
              cell_cmd_o.load = 1'b1;
              tgt_nxt   = p_i;
              sec_nxt   = p_i;
              last_nxt  = p_i;
              state_nxt = ple_pkg::S_SCAN;
            end
          end
          ple_pkg::CMD_REPLACE: begin
            if (!p_in) stat_nxt = ple_pkg::STAT_RANGE;
            else begin
              cell_cmd_o.op    = ple_pkg::CELL_WRITE;
              cell_cmd_o.pos_a = pp;
              cell_cmd_o.pos_b = pp;
            end
          end
          ple_pkg::CMD_INTERCHANGE: begin
            if (!(p_in && q_in)) stat_nxt = ple_pkg::STAT_RANGE;
            else begin
              cell_cmd_o.load = 1'b1;
              tgt_nxt   = p_i;
              sec_nxt   = q_i;
              last_nxt  = (p_i > q_i) ? p_i : q_i;
              state_nxt = ple_pkg::S_SCAN;
            end
          end
          ple_pkg::CMD_MEDIAN: begin
            if (count_r == '0) stat_nxt = ple_pkg::STAT_UNDERFLOW;
            else begin
              cell_cmd_o.load = 1'b1;
              tgt_nxt   = med_i;
              sec_nxt   = med_i;
              last_nxt  = med_i;
              state_nxt = ple_pkg::S_SCAN;
            end
          end
          ple_pkg::CMD_REVERSE: begin
            if (count_r > CW'(1)) begin
              m_nxt     = IW'(count_r - 1'b1);
              state_nxt = ple_pkg::S_REV;
            end
          end
          ple_pkg::CMD_CLEAR: count_nxt = '0;
          default: stat_nxt = ple_pkg::STAT_OK;
        endcase
      end

      // entry k sits at the head of the read chain this cycle
      ple_pkg::S_SCAN: begin
        k_nxt = IW'(k_r + 1'b1);
        if (k_r == tgt_r) tmp_a_nxt = rd_head_i;
        if (k_r == sec_r) tmp_b_nxt = rd_head_i;
        if (k_r == last_r) begin
          if (cmd_r == ple_pkg::CMD_INTERCHANGE) state_nxt = ple_pkg::S_SWAP;
          else state_nxt = ple_pkg::S_DONE;
          if (cmd_r == ple_pkg::CMD_REMOVE) begin
            cell_cmd_o.op    = ple_pkg::CELL_REMOVE;
            cell_cmd_o.pos_a = PW'(tgt_r);
            count_nxt        = CW'(count_r - 1'b1);
          end
        end
      end

      ple_pkg::S_SWAP: begin
        cell_cmd_o.op    = ple_pkg::CELL_WRITE;
        cell_cmd_o.pos_a = PW'(tgt_r);
        cell_cmd_o.pos_b = PW'(sec_r);
        data_a_o         = tmp_b_r;
        data_b_o         = tmp_a_r;
        state_nxt        = ple_pkg::S_DONE;
      end

      // one rotation step per cycle, top slot moving down to 1
      ple_pkg::S_REV: begin
        cell_cmd_o.op    = ple_pkg::CELL_ROTATE;
        cell_cmd_o.pos_a = PW'(m_r);
        m_nxt            = IW'(m_r - 1'b1);
        if (m_r == IW'(1)) state_nxt = ple_pkg::S_DONE;
      end

      ple_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = stat_r;
          out_tdata_nxt = {7'b0, (count_r == FULL_CNT), (count_r == '0), cnt_p[6:0],
                           rd_ext[31:0]};
          state_nxt     = ple_pkg::S_IDLE;
        end
      end

      default: state_nxt = ple_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= ple_pkg::cmd_t'(in_tuser);
      p_r   <= in_tdata[6:0];
      q_r   <= in_tdata[13:7];
      val_r <= val_ext[ENTRY_WIDTH-1:0];
    end
    k_r         <= k_nxt;
    tgt_r       <= tgt_nxt;
    sec_r       <= sec_nxt;
    last_r      <= last_nxt;
    m_r         <= m_nxt;
    tmp_a_r     <= tmp_a_nxt;
    tmp_b_r     <= tmp_b_nxt;
    stat_r      <= stat_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ple_pkg::STAT_OVERFLOW) |-> out_tdata[40])
    else $error("overflow reported on a list that is not full");

  a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ple_pkg::STAT_UNDERFLOW) |-> out_tdata[39])
    else $error("underflow reported on a list that is not empty");

  a_err_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ple_pkg::STAT_OK) |-> (out_tdata[31:0] == '0))
    else $error("read word returned with an error status");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::S_SCAN) |=> (count_r == $past(count_r)) ||
                                     (count_r == $past(count_r) - 1'b1))
    else $error("count moved by more than one during a scan");

endmodule

// ----- rtl/core/positional_list_engine_unit.sv -----
// Top level of the positional list engine: cell chain plus command sequencer.
//
// Usage: one command word enters on the in_ stream (tuser = command, tdata =
// position, second position, value) and exactly one result word leaves on the
// out_ stream (tuser = status, tdata = read word, count, empty and full flags).
// The list lives in a chain of CAPACITY cells; every cell holds one entry and
// takes its neighbor's word on insert, remove and rotate steps, and a parallel
// read chain shifts all entries toward cell 0 one step a cycle.
// Path of a command from its accept to out_tvalid, one command at a time:
//   insert, replace, clear and every error: S_EXEC, then S_DONE;
//   retrieve, remove, median: S_EXEC, S_SCAN up to the index, then S_DONE;
//   interchange: S_EXEC, S_SCAN up to the larger position, S_SWAP, S_DONE;
//   reverse: S_EXEC, count - 1 rotation steps in S_REV (none below 2), S_DONE.
// in_tready is high only while no command is in flight, so the next command
// can be accepted in the same cycle that out_tvalid rises.
// The result sits in an output register; when the receiver holds out_tready low
// the finished result waits there and the sequencer stalls before loading the next one.
// Reset (synchronous, rst_n low) empties the list and drops any pending result;
// entry words are left as they are and are never read before being written.
module positional_list_engine_unit #(
  parameter int CAPACITY    = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[6:0], second_position[13:7], value[45:14]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], entry_count[38:32], is_empty[39],
                                  // is_full[40]
  output logic [1:0]  out_tuser   // status[1:0]
);

  ple_pkg::cell_cmd_t      cell_cmd;
  logic [ENTRY_WIDTH-1:0]  data_a, data_b;
  logic [ENTRY_WIDTH-1:0]  ent [CAPACITY];
  logic [ENTRY_WIDTH-1:0]  rdv [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] up_w, dn_w, rd_w;

    if (g == 0) begin : g_bot
      assign up_w = ent[0];
    end else begin : g_mid
      assign up_w = ent[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign dn_w = ent[g];
      assign rd_w = '0;
    end else begin : g_low
      assign dn_w = ent[g+1];
      assign rd_w = rdv[g+1];
    end

    ple_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk      (clk),
      .cmd_i    (cell_cmd),
      .data_a_i (data_a),
      .data_b_i (data_b),
      .up_i     (up_w),
      .dn_i     (dn_w),
      .head_i   (ent[0]),
      .rd_i     (rd_w),
      .data_o   (ent[g]),
      .rd_o     (rdv[g])
    );
  end

  ple_ctrl #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .rd_head_i  (rdv[0]),
    .cell_cmd_o (cell_cmd),
    .data_a_o   (data_a),
    .data_b_o   (data_b)
  );

endmodule
